@@ design/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assertion macros
// concurrent assertion helpers, empty when built for synthesis
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLIES(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle implication failed");
`define ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle implication failed");
`else
`define ASSERT_IMPLIES(name, clk, rst, ante, cons)
`define ASSERT_NEXT(name, clk, rst, ante, cons)
`endif
`endif

@@ design/cdrc_pkg.sv @@
// ----------------------------------------------------------------------------
// cdrc_pkg
// shared types and constants of the capability derive/revoke checker
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cdrc_pkg;

   localparam int TYPE_W    = 3;
   localparam int KEY_W     = 16;
   localparam int LOW_W     = 40;
   localparam int MARK_W    = 16;
   localparam int HIGH_W    = 16;
   localparam int RIGHTS_W  = 8;
   localparam int RWX_W     = 3;
   localparam int PERM_W    = 8;
   localparam int MODE_W    = 4;
   localparam int CSR_W     = 8;
   localparam int CSR_IDX_W = 1;

   localparam int REGION_SHIFT = 27;
   localparam int PAGE_SHIFT   = 12;

   // byte addresses: region offset << 27 plus carry, napot end reaches 2^43
   localparam int BYTE_W = KEY_W + REGION_SHIFT + 1;

   typedef logic [TYPE_W-1:0]    kind_type;
   typedef logic [CSR_IDX_W-1:0] csr_idx_type;

   localparam kind_type TY_NONE    = 3'd0;
   localparam kind_type TY_TIME    = 3'd1;
   localparam kind_type TY_MEMORY  = 3'd2;
   localparam kind_type TY_PMP     = 3'd3;
   localparam kind_type TY_MONITOR = 3'd4;
   localparam kind_type TY_CHANNEL = 3'd5;
   localparam kind_type TY_SOCKET  = 3'd6;
   localparam kind_type TY_INVALID = 3'd7;

   localparam csr_idx_type CSR_PERM_MASK = 1'd0;
   localparam csr_idx_type CSR_MODE_MASK = 1'd1;

   localparam logic [PERM_W-1:0] PERM_MASK_RESET = 8'd15;
   localparam logic [MODE_W-1:0] MODE_MASK_RESET = 4'd3;

   typedef struct packed {
      kind_type              kind;
      logic [KEY_W-1:0]      key;
      logic [LOW_W-1:0]      low;
      logic [MARK_W-1:0]     mark;
      logic [HIGH_W-1:0]     high;
      logic [RIGHTS_W-1:0]   rights;
   } cap_type;

   typedef struct packed {
      logic revokable;
      logic derivable;
      logic child_ok;
   } verdict_type;

endpackage

@@ design/cdrc_req_if.sv @@
// ----------------------------------------------------------------------------
// cdrc_req_if
// request channel: parent and child capability fields
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface cdrc_req_if;
   import cdrc_pkg::*;

   logic                valid;
   logic                ready;
   logic [TYPE_W-1:0]   parent_type;
   logic [KEY_W-1:0]    parent_key;
   logic [LOW_W-1:0]    parent_low;
   logic [MARK_W-1:0]   parent_mark;
   logic [HIGH_W-1:0]   parent_high;
   logic [RIGHTS_W-1:0] parent_rights;
   logic [TYPE_W-1:0]   child_type;
   logic [KEY_W-1:0]    child_key;
   logic [LOW_W-1:0]    child_low;
   logic [MARK_W-1:0]   child_mark;
   logic [HIGH_W-1:0]   child_high;
   logic [RIGHTS_W-1:0] child_rights;

   modport source (
      output valid, parent_type, parent_key, parent_low, parent_mark, parent_high,
             parent_rights, child_type, child_key, child_low, child_mark, child_high,
             child_rights,
      input  ready
   );

   modport sink (
      input  valid, parent_type, parent_key, parent_low, parent_mark, parent_high,
             parent_rights, child_type, child_key, child_low, child_mark, child_high,
             child_rights,
      output ready
   );

endinterface

@@ design/cdrc_rsp_if.sv @@
// ----------------------------------------------------------------------------
// cdrc_rsp_if
// response channel: revoke and derive flags
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface cdrc_rsp_if;

   logic valid;
   logic ready;
   logic revokable;
   logic derivable;

   modport source (
      output valid, revokable, derivable,
      input  ready
   );

   modport sink (
      input  valid, revokable, derivable,
      output ready
   );

endinterface

@@ design/cdrc_check.sv @@
// ----------------------------------------------------------------------------
// cdrc_check
// combinational revoke/derive decision for one parent/child pair
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cdrc_check (
   input  cdrc_pkg::cap_type           parent,
   input  cdrc_pkg::cap_type           child,
   input  logic [cdrc_pkg::PERM_W-1:0] perm_mask,
   input  logic [cdrc_pkg::MODE_W-1:0] mode_mask,
   output cdrc_pkg::verdict_type       verdict
);
   import cdrc_pkg::*;

   logic [BYTE_W-1:0] mem_bgn;
   logic [BYTE_W-1:0] mem_end;
   logic [BYTE_W-1:0] pmp_a;
   logic [BYTE_W-1:0] pmp_a1;
   logic [BYTE_W-1:0] pmp_bgn;
   logic [BYTE_W-1:0] pmp_end;
   logic [LOW_W-1:0]  p_high_w;
   logic [LOW_W-1:0]  p_mark_w;
   logic [LOW_W-1:0]  c_high_w;
   logic [LOW_W-1:0]  c_mark_w;
   logic [LOW_W-1:0]  c_key_w;
   logic [KEY_W:0]    c_key1;
   logic [HIGH_W:0]   p_high_x;
   logic              same_key;
   logic              rng_in;
   logic              rng_pre;
   logic              rng_mark;
   logic              pmp_in;
   logic              sock_low;
   logic              sock_mark;
   logic              rwx_ok;
   logic              child_ok;
   logic              rev;
   logic              der;

   // memory byte window from the parent's mark and end pages
   assign mem_bgn = ({{(BYTE_W-KEY_W){1'b0}}, parent.key} << REGION_SHIFT)
                  + ({{(BYTE_W-MARK_W){1'b0}}, parent.mark} << PAGE_SHIFT);
   assign mem_end = ({{(BYTE_W-KEY_W){1'b0}}, parent.key} << REGION_SHIFT)
                  + ({{(BYTE_W-HIGH_W){1'b0}}, parent.high} << PAGE_SHIFT);

   // napot: base clears the trailing ones, end is (a | a+1) + 1
   assign pmp_a   = {{(BYTE_W-LOW_W){1'b0}}, child.low};
   assign pmp_a1  = pmp_a + {{(BYTE_W-1){1'b0}}, 1'b1};
   assign pmp_bgn = (pmp_a & pmp_a1) << 2;
   assign pmp_end = ((pmp_a | pmp_a1) + {{(BYTE_W-1){1'b0}}, 1'b1}) << 2;

   assign p_high_w = {{(LOW_W-HIGH_W){1'b0}}, parent.high};
   assign p_mark_w = {{(LOW_W-MARK_W){1'b0}}, parent.mark};
   assign c_high_w = {{(LOW_W-HIGH_W){1'b0}}, child.high};
   assign c_mark_w = {{(LOW_W-MARK_W){1'b0}}, child.mark};
   assign c_key_w  = {{(LOW_W-KEY_W){1'b0}}, child.key};
   assign c_key1   = {1'b0, child.key} + {{KEY_W{1'b0}}, 1'b1};
   assign p_high_x = {1'b0, parent.high};

   assign same_key  = parent.key == child.key;
   assign rng_in    = (parent.low <= child.low) && (c_high_w <= p_high_w);
   assign rng_pre   = (parent.low == child.low) && (c_high_w <= p_high_w);
   assign rng_mark  = (p_mark_w <= child.low) && (c_high_w <= p_high_w);
   assign pmp_in    = (mem_bgn <= pmp_bgn) && (pmp_end <= mem_end);
   assign sock_low  = (parent.low <= c_key_w) && (c_key1 <= p_high_x);
   assign sock_mark = (parent.mark <= child.key) && (c_key1 <= p_high_x);
   assign rwx_ok    = (child.rights[RWX_W-1:0] & ~parent.rights[RWX_W-1:0]) == '0;

   always_comb begin
      child_ok = 1'b0;
      if (child.kind inside {TY_TIME, TY_MEMORY, TY_MONITOR, TY_CHANNEL}) begin
         child_ok = (child.low == c_mark_w) && (child.low < c_high_w);
      end else if (child.kind == TY_PMP) begin
         child_ok = child.mark == '0;
      end else if (child.kind == TY_SOCKET) begin
         child_ok = ((child.rights & ~perm_mask) == '0)
                 && ((child.mark & ~{{(MARK_W-MODE_W){1'b0}}, mode_mask}) == '0);
      end
   end

   always_comb begin
      rev = 1'b0;
      der = 1'b0;
      case (parent.kind)
         TY_TIME: begin
            rev = (child.kind == TY_TIME) && same_key && rng_in;
            der = (child.kind == TY_TIME) && same_key && rng_pre;
         end
         TY_MEMORY: begin
            if (child.kind == TY_PMP) begin
               rev = pmp_in;
               der = pmp_in && rwx_ok;
            end else begin
               rev = (child.kind == TY_MEMORY) && same_key && rng_in;
               der = (child.kind == TY_MEMORY) && same_key && rng_mark && rwx_ok;
            end
         end
         TY_MONITOR: begin
            rev = (child.kind == TY_MONITOR) && rng_in;
            der = (child.kind == TY_MONITOR) && rng_mark;
         end
         TY_CHANNEL: begin
            if (child.kind == TY_SOCKET) begin
               rev = sock_low;
               der = (child.low == '0) && sock_mark;
            end else begin
               rev = (child.kind == TY_CHANNEL) && rng_in;
               der = (child.kind == TY_CHANNEL) && rng_mark;
            end
         end
         TY_SOCKET: begin
            // revoke reads the child as a socket whatever its type
            rev = (parent.low == '0) && (child.low != '0) && same_key;
            der = (child.kind == TY_SOCKET) && same_key && (parent.low == '0)
               && (child.low != '0) && (parent.mark == child.mark)
               && (parent.rights == child.rights);
         end
         default: begin
            rev = 1'b0;
            der = 1'b0;
         end
      endcase
   end

   assign verdict.revokable = rev;
   assign verdict.derivable = der && child_ok;
   assign verdict.child_ok  = child_ok;

endmodule

@@ design/capability_derive_revoke_check.sv @@
// ----------------------------------------------------------------------------
// capability_derive_revoke_check
// decides whether a parent capability may revoke a child and whether the
// child may be derived from it
// ----------------------------------------------------------------------------
//  channel  | dir | payload                                  | handshake
//  req_ch   | in  | parent and child type/key/low/mark/...   | valid/ready
//  rsp_ch   | out | revokable, derivable                     | valid/ready
//  csr_*    | in  | perm mask (index 0), mode mask (index 1) | write enable
//
//  two register stages: a request is captured in the request register, checked
//  by combinational logic, and its flags land in the response register
//  one request per cycle when the response side keeps up
//  the response register stalls on rsp ready low; the request register
//  keeps accepting until both stages hold a request
//  reset is synchronous, clears the valid bits and reloads the csr masks
//  with their reset values
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module capability_derive_revoke_check (
   input  logic                           clock,
   input  logic                           reset,
   cdrc_req_if.sink                       req_ch,
   cdrc_rsp_if.source                     rsp_ch,
   input  logic                           csr_we,
   input  logic [cdrc_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [cdrc_pkg::CSR_W-1:0]     csr_wdata
);
   import cdrc_pkg::*;

   logic [PERM_W-1:0] perm_mask_ff;
   logic [PERM_W-1:0] perm_mask_in;
   logic [MODE_W-1:0] mode_mask_ff;
   logic [MODE_W-1:0] mode_mask_in;

   logic              s1_valid_ff;
   logic              s1_valid_in;
   cap_type           s1_parent_ff;
   cap_type           s1_parent_in;
   cap_type           s1_child_ff;
   cap_type           s1_child_in;

   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   verdict_type       rsp_verdict_ff;
   verdict_type       rsp_verdict_in;

   verdict_type       chk;
   logic              s1_take;
   logic              s2_take;
   logic              s1_no_rules;

   // csr writes
   always_comb begin
      perm_mask_in = perm_mask_ff;
      mode_mask_in = mode_mask_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_PERM_MASK: perm_mask_in = csr_wdata[PERM_W-1:0];
            CSR_MODE_MASK: mode_mask_in = csr_wdata[MODE_W-1:0];
            default: begin
               perm_mask_in = perm_mask_ff;
               mode_mask_in = mode_mask_ff;
            end
         endcase
      end
   end

   assign s2_take      = !rsp_valid_ff || rsp_ch.ready;
   assign s1_take      = !s1_valid_ff || s2_take;
   assign req_ch.ready = s1_take;

   assign s1_valid_in  = s1_take ? req_ch.valid : s1_valid_ff;
   assign rsp_valid_in = s2_take ? s1_valid_ff : rsp_valid_ff;

   always_comb begin
      s1_parent_in        = s1_parent_ff;
      s1_child_in         = s1_child_ff;
      if (s1_take && req_ch.valid) begin
         s1_parent_in.kind   = req_ch.parent_type;
         s1_parent_in.key    = req_ch.parent_key;
         s1_parent_in.low    = req_ch.parent_low;
         s1_parent_in.mark   = req_ch.parent_mark;
         s1_parent_in.high   = req_ch.parent_high;
         s1_parent_in.rights = req_ch.parent_rights;
         s1_child_in.kind    = req_ch.child_type;
         s1_child_in.key     = req_ch.child_key;
         s1_child_in.low     = req_ch.child_low;
         s1_child_in.mark    = req_ch.child_mark;
         s1_child_in.high    = req_ch.child_high;
         s1_child_in.rights  = req_ch.child_rights;
      end
   end

   cdrc_check u_check (
      .parent    (s1_parent_ff),
      .child     (s1_child_ff),
      .perm_mask (perm_mask_ff),
      .mode_mask (mode_mask_ff),
      .verdict   (chk)
   );

   assign rsp_verdict_in = (s2_take && s1_valid_ff) ? chk : rsp_verdict_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         perm_mask_ff <= PERM_MASK_RESET;
         mode_mask_ff <= MODE_MASK_RESET;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         perm_mask_ff <= perm_mask_in;
         mode_mask_ff <= mode_mask_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_parent_ff   <= s1_parent_in;
      s1_child_ff    <= s1_child_in;
      rsp_verdict_ff <= rsp_verdict_in;
   end

   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.revokable = rsp_verdict_ff.revokable;
   assign rsp_ch.derivable = rsp_verdict_ff.derivable;

   // parent kinds that carry no rules
   assign s1_no_rules = s1_parent_ff.kind inside {TY_NONE, TY_PMP, TY_INVALID};

   // checks
   `ASSERT_NEXT(a_req_lands, clock, reset, req_ch.valid && req_ch.ready, s1_valid_ff)
   `ASSERT_NEXT(a_s1_moves, clock, reset, s1_valid_ff && s2_take, rsp_valid_ff)
   `ASSERT_IMPLIES(a_derive_valid, clock, reset, s1_valid_ff && chk.derivable, chk.child_ok)
   `ASSERT_IMPLIES(a_no_rules, clock, reset, s1_valid_ff && s1_no_rules, !chk.revokable && !chk.derivable)

endmodule
